FILE: rtl/m4a_pkg.sv
package m4a_pkg;

  localparam int DATA_W   = 32;
  localparam int IDX_W    = 4;
  localparam int MODE_W   = 2;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam int DIM_DEF  = 4;
  localparam int FRAC_DEF = 16;

  typedef enum logic [MODE_W-1:0] {
    OP_ADD   = 2'd0,
    OP_SUB   = 2'd1,
    OP_MUL   = 2'd2,
    OP_SCALE = 2'd3
  } op_t;

  typedef enum logic {
    REG_OP_MODE = 1'b0,
    REG_SCALE   = 1'b1
  } reg_t;

  localparam op_t                      MODE_RST  = OP_MUL;
  localparam logic signed [DATA_W-1:0] SCALE_RST = 32'sd65536;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ISSUE,
    ST_WAIT
  } seq_state_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } tok_t;

  typedef struct packed {
    tok_t             tok;
    logic [IDX_W-1:0] index;
    logic             last_res;
  } seq_ctl_t;

endpackage

FILE: rtl/m4a_if.sv
interface m4a_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [m4a_pkg::DATA_W-1:0]   a_elem;
  logic signed [m4a_pkg::DATA_W-1:0]   b_elem;
  logic        [m4a_pkg::IDX_W-1:0]    elem_index;

  modport source (output valid, a_elem, b_elem, elem_index, input ready);
  modport sink   (input valid, a_elem, b_elem, elem_index, output ready);
endinterface

interface m4a_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [m4a_pkg::DATA_W-1:0]   result_elem;
  logic        [m4a_pkg::IDX_W-1:0]    result_index;
  logic                                last_result;

  modport source (output valid, result_elem, result_index, last_result, input ready);
  modport sink   (input valid, result_elem, result_index, last_result, output ready);
endinterface

FILE: rtl/m4a_store.sv
module m4a_store #(
  parameter int DIM = m4a_pkg::DIM_DEF,
  localparam int NELEM = DIM * DIM,
  localparam int AW = $clog2(NELEM)
) (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [AW-1:0]                      wr_addr,
  input  logic signed [m4a_pkg::DATA_W-1:0]  wr_a,
  input  logic signed [m4a_pkg::DATA_W-1:0]  wr_b,
  input  logic [AW-1:0]                      a_addr,
  input  logic [AW-1:0]                      b_addr,
  output logic signed [m4a_pkg::DATA_W-1:0]  a_rd,
  output logic signed [m4a_pkg::DATA_W-1:0]  b_rd
);

  logic signed [m4a_pkg::DATA_W-1:0] a_mem [NELEM];
  logic signed [m4a_pkg::DATA_W-1:0] b_mem [NELEM];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      a_mem[wr_addr] <= wr_a;
      b_mem[wr_addr] <= wr_b;
    end
    a_rd <= a_mem[a_addr];
    b_rd <= b_mem[b_addr];
  end

endmodule

FILE: rtl/m4a_seq.sv
module m4a_seq #(
  parameter int DIM = m4a_pkg::DIM_DEF,
  localparam int NELEM = DIM * DIM,
  localparam int AW = $clog2(NELEM),
  localparam int CW = $clog2(DIM)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [m4a_pkg::IDX_W-1:0]    in_index,
  output logic                         in_ready,
  output logic                         wr_en,
  output logic [AW-1:0]                wr_addr,
  input  m4a_pkg::op_t                 mode,
  output logic [AW-1:0]                a_addr,
  output logic [AW-1:0]                b_addr,
  output m4a_pkg::seq_ctl_t            ctl,
  input  logic                         taken
);

  m4a_pkg::seq_state_t state, state_next;
  logic [CW-1:0] r, r_next;
  logic [CW-1:0] c, c_next;
  logic [CW-1:0] k, k_next;
  logic          start;
  logic          k_last;
  logic          rc_last;
  logic [AW-1:0] pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= m4a_pkg::ST_LOAD;
      r     <= '0;
      c     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      r     <= r_next;
      c     <= c_next;
      k     <= k_next;
    end
  end

  always_comb begin
    in_ready = (state == m4a_pkg::ST_LOAD);
    wr_en    = in_valid && in_ready && (int'(in_index) < NELEM);
    wr_addr  = AW'(in_index);
    start    = wr_en && (int'(in_index) == NELEM - 1);

    k_last  = (mode == m4a_pkg::OP_MUL) ? (k == CW'(DIM - 1)) : 1'b1;
    rc_last = (r == CW'(DIM - 1)) && (c == CW'(DIM - 1));
    pos     = AW'(r) * AW'(DIM) + AW'(c);

    if (mode == m4a_pkg::OP_MUL) begin
      a_addr = AW'(r) * AW'(DIM) + AW'(k);
      b_addr = AW'(k) * AW'(DIM) + AW'(c);
    end else begin
      a_addr = pos;
      b_addr = pos;
    end

    ctl.tok.vld   = (state == m4a_pkg::ST_ISSUE);
    ctl.tok.first = (k == '0);
    ctl.tok.last  = k_last;
    ctl.index     = m4a_pkg::IDX_W'(pos);
    ctl.last_res  = rc_last;

    state_next = state;
    r_next     = r;
    c_next     = c;
    k_next     = k;

    unique case (state)
      m4a_pkg::ST_LOAD: begin
        if (start) begin
          state_next = m4a_pkg::ST_ISSUE;
          r_next     = '0;
          c_next     = '0;
          k_next     = '0;
        end
      end
      m4a_pkg::ST_ISSUE: begin
        if (k_last) begin
          state_next = m4a_pkg::ST_WAIT;
          k_next     = '0;
        end else begin
          k_next = k + 1'b1;
        end
      end
      m4a_pkg::ST_WAIT: begin
        if (taken) begin
          if (rc_last) begin
            state_next = m4a_pkg::ST_LOAD;
            r_next     = '0;
            c_next     = '0;
          end else begin
            state_next = m4a_pkg::ST_ISSUE;
            if (c == CW'(DIM - 1)) begin
              c_next = '0;
              r_next = r + 1'b1;
            end else begin
              c_next = c + 1'b1;
            end
          end
        end
      end
      default: begin
        state_next = m4a_pkg::ST_LOAD;
      end
    endcase
  end

  a_taken_in_wait: assert property (@(posedge clk) disable iff (rst)
    taken |-> state == m4a_pkg::ST_WAIT)
    else $error("result taken outside wait state");

  a_start_issues: assert property (@(posedge clk) disable iff (rst)
    start |=> state == m4a_pkg::ST_ISSUE)
    else $error("last element did not start a run");

  a_wait_holds: assert property (@(posedge clk) disable iff (rst)
    (state == m4a_pkg::ST_WAIT) && !taken
      |=> (state == m4a_pkg::ST_WAIT) && $stable(r) && $stable(c))
    else $error("position moved before result was taken");

endmodule

FILE: rtl/m4a_alu.sv
module m4a_alu #(
  parameter int DIM = m4a_pkg::DIM_DEF,
  parameter int FRAC_BITS = m4a_pkg::FRAC_DEF,
  localparam int NELEM = DIM * DIM,
  localparam int ACC_W = 2 * m4a_pkg::DATA_W + $clog2(DIM)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  m4a_pkg::op_t                       mode,
  input  logic signed [m4a_pkg::DATA_W-1:0]  scale,
  input  logic signed [m4a_pkg::DATA_W-1:0]  a_rd,
  input  logic signed [m4a_pkg::DATA_W-1:0]  b_rd,
  input  m4a_pkg::seq_ctl_t                  ctl,
  output logic                               taken,
  m4a_out_if.source                          result_ch
);

  localparam int DW = m4a_pkg::DATA_W;
  localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW - 1){1'b1}}};
  localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW - 1){1'b0}}};

  m4a_pkg::tok_t s1, s2;
  logic signed [DW:0]        sum_c;
  logic signed [2*DW-1:0]    prod_c;
  logic signed [DW-1:0]      opb;
  logic signed [ACC_W-1:0]   term_c;
  logic signed [ACC_W-1:0]   term;
  logic signed [ACC_W-1:0]   acc;
  logic                      acc_done;
  logic signed [ACC_W-1:0]   shifted;
  logic                      fits;
  logic signed [DW-1:0]      sat;
  logic                      out_valid;
  logic signed [DW-1:0]      out_elem;
  logic [m4a_pkg::IDX_W-1:0] out_index;
  logic                      out_last;

  // shared operand unit: one multiplier and one adder, mode selects which result is the term
  always_comb begin
    opb    = (mode == m4a_pkg::OP_SCALE) ? scale : b_rd;
    sum_c  = (mode == m4a_pkg::OP_SUB) ? (a_rd - b_rd) : (a_rd + b_rd);
    prod_c = a_rd * opb;
    unique case (mode)
      m4a_pkg::OP_ADD,
      m4a_pkg::OP_SUB:   term_c = ACC_W'(sum_c);
      m4a_pkg::OP_MUL,
      m4a_pkg::OP_SCALE: term_c = ACC_W'(prod_c);
    endcase
  end

  always_comb begin
    if (mode == m4a_pkg::OP_MUL || mode == m4a_pkg::OP_SCALE) begin
      shifted = acc >>> FRAC_BITS;
    end else begin
      shifted = acc;
    end
    fits = (&shifted[ACC_W-1:DW-1]) || !(|shifted[ACC_W-1:DW-1]);
    if (fits) begin
      sat = shifted[DW-1:0];
    end else if (shifted[ACC_W-1]) begin
      sat = SAT_MIN;
    end else begin
      sat = SAT_MAX;
    end
    taken = acc_done && (!out_valid || result_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1        <= '0;
      s2        <= '0;
      acc_done  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1 <= ctl.tok;
      s2 <= s1;
      if (s2.vld && s2.last) begin
        acc_done <= 1'b1;
      end else if (taken) begin
        acc_done <= 1'b0;
      end
      if (taken) begin
        out_valid <= 1'b1;
      end else if (result_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1.vld) begin
      term <= term_c;
    end
    if (s2.vld) begin
      acc <= s2.first ? term : (acc + term);
    end
    if (taken) begin
      out_elem  <= sat;
      out_index <= ctl.index;
      out_last  <= ctl.last_res;
    end
  end

  assign result_ch.valid        = out_valid;
  assign result_ch.result_elem  = out_elem;
  assign result_ch.result_index = out_index;
  assign result_ch.last_result  = out_last;

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s2.vld |-> !acc_done)
    else $error("term reached accumulator holding a finished result");

  a_done_kept: assert property (@(posedge clk) disable iff (rst)
    acc_done && !taken |=> acc_done)
    else $error("finished result dropped before output");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_index == m4a_pkg::IDX_W'(NELEM - 1))
    else $error("last flag on wrong position");

endmodule

FILE: rtl/matrix4_arith_unit.sv
// channel    | dir | payload                                   | request
// elem_ch    | in  | a_elem, b_elem, elem_index                | one element pair
// result_ch  | out | result_elem, result_index, last_result     | one result element
// apb        | cfg | 0x0 op_mode, 0x4 scale_factor              | register write
//
// the position DIM*DIM-1 starts a run of DIM*DIM results
// each result takes one term for add, subtract and scale, DIM terms
// for matrix multiply, all through the shared operand unit and the single accumulator
// elem_ch is not ready during a run; a stalled result holds the next one in the accumulator
// synchronous reset clears control state and registers; stores are undefined until loaded
module matrix4_arith_unit #(
  parameter int DIM = m4a_pkg::DIM_DEF,
  parameter int FRAC_BITS = m4a_pkg::FRAC_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [m4a_pkg::PADDR_W-1:0]   paddr,
  input  logic [m4a_pkg::PDATA_W-1:0]   pwdata,
  output logic [m4a_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  m4a_in_if.sink                        elem_ch,
  m4a_out_if.source                     result_ch
);

  localparam int NELEM = DIM * DIM;
  localparam int AW = $clog2(NELEM);

  m4a_pkg::op_t                       op_mode;
  logic signed [m4a_pkg::DATA_W-1:0]  scale_factor;
  logic                               cfg_wr;
  m4a_pkg::reg_t                      reg_sel;

  logic                               wr_en;
  logic [AW-1:0]                      wr_addr;
  logic [AW-1:0]                      a_addr;
  logic [AW-1:0]                      b_addr;
  logic signed [m4a_pkg::DATA_W-1:0]  a_rd;
  logic signed [m4a_pkg::DATA_W-1:0]  b_rd;
  m4a_pkg::seq_ctl_t                  ctl;
  logic                               taken;

  always_comb begin
    pready  = 1'b1;
    reg_sel = m4a_pkg::reg_t'(paddr[2]);
    cfg_wr  = psel && penable && pwrite && pready;
    unique case (reg_sel)
      m4a_pkg::REG_OP_MODE: prdata = m4a_pkg::PDATA_W'(op_mode);
      m4a_pkg::REG_SCALE:   prdata = scale_factor;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode      <= m4a_pkg::MODE_RST;
      scale_factor <= m4a_pkg::SCALE_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        m4a_pkg::REG_OP_MODE: op_mode      <= m4a_pkg::op_t'(pwdata[m4a_pkg::MODE_W-1:0]);
        m4a_pkg::REG_SCALE:   scale_factor <= pwdata;
      endcase
    end
  end

  m4a_seq #(
    .DIM (DIM)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (elem_ch.valid),
    .in_index (elem_ch.elem_index),
    .in_ready (elem_ch.ready),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .mode     (op_mode),
    .a_addr   (a_addr),
    .b_addr   (b_addr),
    .ctl      (ctl),
    .taken    (taken)
  );

  m4a_store #(
    .DIM (DIM)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_a    (elem_ch.a_elem),
    .wr_b    (elem_ch.b_elem),
    .a_addr  (a_addr),
    .b_addr  (b_addr),
    .a_rd    (a_rd),
    .b_rd    (b_rd)
  );

  m4a_alu #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_alu (
    .clk       (clk),
    .rst       (rst),
    .mode      (op_mode),
    .scale     (scale_factor),
    .a_rd      (a_rd),
    .b_rd      (b_rd),
    .ctl       (ctl),
    .taken     (taken),
    .result_ch (result_ch)
  );

endmodule

FILE: bench/tb_matrix4_arith_unit.sv
`timescale 1ns / 100ps

localparam int NELEM = m4a_pkg::DIM_DEF * m4a_pkg::DIM_DEF;

typedef struct packed {
  logic signed [m4a_pkg::DATA_W-1:0] elem;
  logic [m4a_pkg::IDX_W-1:0]         index;
  logic                              last;
} mat_result_t;

class m4a_scoreboard;
  logic signed [m4a_pkg::DATA_W-1:0] a_mat [NELEM];
  logic signed [m4a_pkg::DATA_W-1:0] b_mat [NELEM];
  m4a_pkg::op_t                      mode;
  logic signed [m4a_pkg::DATA_W-1:0] k;
  mat_result_t                       pending_elems [$];
  int                                errors;
  int                                n_loads;
  int                                n_runs;
  int                                n_results;

  function new();
    mode = m4a_pkg::OP_MUL;
    k = 32'sd65536;
    errors = 0;
    n_loads = 0;
    n_runs = 0;
    n_results = 0;
  endfunction

  function void set_reg(m4a_pkg::reg_t r, logic [m4a_pkg::DATA_W-1:0] v);
    if (r == m4a_pkg::REG_OP_MODE) begin
      mode = m4a_pkg::op_t'(v[m4a_pkg::MODE_W-1:0]);
    end else begin
      k = v;
    end
  endfunction

  function logic signed [m4a_pkg::DATA_W-1:0] clamp32(logic signed [79:0] v);
    if (v > 80'sd2147483647) return 32'sh7fffffff;
    if (v < -80'sd2147483648) return 32'sh80000000;
    return v[m4a_pkg::DATA_W-1:0];
  endfunction

  function void compute_matrix_op();
    logic signed [79:0] acc;
    mat_result_t        res;
    int                 i;
    int                 j;
    for (i = 0; i < NELEM; i++) begin
      case (mode)
        m4a_pkg::OP_ADD: begin
          acc = a_mat[i];
          acc = acc + b_mat[i];
        end
        m4a_pkg::OP_SUB: begin
          acc = a_mat[i];
          acc = acc - b_mat[i];
        end
        m4a_pkg::OP_MUL: begin
          acc = '0;
          for (j = 0; j < m4a_pkg::DIM_DEF; j++) begin
            acc = acc + a_mat[(i / m4a_pkg::DIM_DEF) * m4a_pkg::DIM_DEF + j]
                      * b_mat[j * m4a_pkg::DIM_DEF + i % m4a_pkg::DIM_DEF];
          end
          acc = acc >>> m4a_pkg::FRAC_DEF;
        end
        default: begin
          acc = a_mat[i];
          acc = (acc * k) >>> m4a_pkg::FRAC_DEF;
        end
      endcase
      res.elem = clamp32(acc);
      res.index = m4a_pkg::IDX_W'(i);
      res.last = (i == NELEM - 1);
      pending_elems.push_back(res);
    end
  endfunction

  function void load_elem(logic signed [m4a_pkg::DATA_W-1:0] a,
                          logic signed [m4a_pkg::DATA_W-1:0] b,
                          logic [m4a_pkg::IDX_W-1:0] idx);
    n_loads++;
    a_mat[idx] = a;
    b_mat[idx] = b;
    if (idx == m4a_pkg::IDX_W'(NELEM - 1)) begin
      n_runs++;
      compute_matrix_op();
    end
  endfunction

  function void check_result(logic signed [m4a_pkg::DATA_W-1:0] elem,
                             logic [m4a_pkg::IDX_W-1:0] idx, logic last);
    mat_result_t want;
    if (pending_elems.size() == 0) begin
      $error("result with nothing pending: result_index %0d result_elem %0d", idx, elem);
      errors++;
      return;
    end
    want = pending_elems.pop_front();
    n_results++;
    if (elem !== want.elem) begin
      $error("result_elem mismatch: expected %0d, actual %0d", want.elem, elem);
      errors++;
    end
    if (idx !== want.index) begin
      $error("result_index mismatch: expected %0d, actual %0d", want.index, idx);
      errors++;
    end
    if (last !== want.last) begin
      $error("last_result mismatch: expected %0d, actual %0d", want.last, last);
      errors++;
    end
  endfunction
endclass

module tb_matrix4_arith_unit;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_TARGET = 310;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 132;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [m4a_pkg::PADDR_W-1:0] paddr = '0;
  logic [m4a_pkg::PDATA_W-1:0] pwdata = '0;
  logic [m4a_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  m4a_in_if  elem_ch ();
  m4a_out_if result_ch ();

  matrix4_arith_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .elem_ch   (elem_ch),
    .result_ch (result_ch)
  );

  m4a_scoreboard sb = new();

  int cycle_cnt = 0;
  int elem_gap_max = 0;
  int result_gap_max = 0;
  bit hold_done = 1'b0;

  logic [m4a_pkg::DATA_W-1:0] dir_a [NELEM] = '{
    32'h7fffffff, 32'h80000000, 32'h00000000, 32'hffffffff,
    32'h00000001, 32'h00010000, 32'hffff0000, 32'h00018000,
    32'hfffe8000, 32'h00000003, 32'hfffffffd, 32'h00008000,
    32'hffff7fff, 32'h000f4240, 32'hfff0bdc0, 32'h40000000
  };
  logic [m4a_pkg::DATA_W-1:0] dir_b [NELEM] = '{
    32'h80000000, 32'h80000000, 32'h7fffffff, 32'h00000001,
    32'hffffffff, 32'h00010000, 32'h00010000, 32'hfffe8000,
    32'h00000002, 32'hfffffffd, 32'h00000007, 32'h00008000,
    32'h0000ffff, 32'hffffffff, 32'h0001e240, 32'h7fff0000
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      sb.check_result(result_ch.result_elem, result_ch.result_index, result_ch.last_result);
    end
  end

  function automatic logic [m4a_pkg::DATA_W-1:0] pick_val();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h00000000;
      3: return 32'hffffffff;
      4, 5: return $urandom;
      default: return $urandom_range(0, 32'h80000) - 32'h40000;
    endcase
  endfunction

  function automatic logic [m4a_pkg::DATA_W-1:0] pick_scale();
    case ($urandom_range(0, 6))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h00000000;
      3: return 32'h00010000;
      4: return 32'hffff0000;
      5: return $urandom;
      default: return $urandom_range(0, 32'h100000) - 32'h80000;
    endcase
  endfunction

  task automatic write_reg(input m4a_pkg::reg_t r, input logic [m4a_pkg::PDATA_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(r, v);
    @(posedge clk);
  endtask

  task automatic send_elem(input logic [m4a_pkg::DATA_W-1:0] a,
                           input logic [m4a_pkg::DATA_W-1:0] b,
                           input logic [m4a_pkg::IDX_W-1:0] idx);
    int gap;
    gap = $urandom_range(0, elem_gap_max);
    if (gap > 0) begin
      elem_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    elem_ch.valid <= 1'b1;
    elem_ch.a_elem <= a;
    elem_ch.b_elem <= b;
    elem_ch.elem_index <= idx;
    do @(posedge clk); while (!elem_ch.ready);
    sb.load_elem(a, b, idx);
  endtask

  task automatic settle(input int tail);
    elem_ch.valid <= 1'b0;
    while (sb.pending_elems.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic directed_op(input m4a_pkg::op_t m, input logic [m4a_pkg::PDATA_W-1:0] kval,
                             input logic [m4a_pkg::DATA_W-1:0] a,
                             input logic [m4a_pkg::DATA_W-1:0] b);
    write_reg(m4a_pkg::REG_OP_MODE, m);
    write_reg(m4a_pkg::REG_SCALE, kval);
    send_elem(a, b, m4a_pkg::IDX_W'(NELEM - 1));
    settle(8);
  endtask

  // full shuffled loads dominate, the rest are partial loads, lone triggers and stray loads
  task automatic load_burst();
    logic [m4a_pkg::IDX_W-1:0] order [NELEM-1];
    logic [m4a_pkg::IDX_W-1:0] tmp;
    int                        shape;
    int                        j;
    int                        r;
    shape = $urandom_range(0, 9);
    if (shape <= 5) begin
      for (j = 0; j < NELEM - 1; j++) order[j] = m4a_pkg::IDX_W'(j);
      for (j = NELEM - 2; j > 0; j--) begin
        r = $urandom_range(0, j);
        tmp = order[j];
        order[j] = order[r];
        order[r] = tmp;
      end
      for (j = 0; j < NELEM - 1; j++) send_elem(pick_val(), pick_val(), order[j]);
      send_elem(pick_val(), pick_val(), m4a_pkg::IDX_W'(NELEM - 1));
    end else if (shape <= 7) begin
      repeat ($urandom_range(1, 6)) begin
        send_elem(pick_val(), pick_val(), m4a_pkg::IDX_W'($urandom_range(0, NELEM - 2)));
      end
      send_elem(pick_val(), pick_val(), m4a_pkg::IDX_W'(NELEM - 1));
    end else if (shape == 8) begin
      send_elem(pick_val(), pick_val(), m4a_pkg::IDX_W'(NELEM - 1));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        send_elem(pick_val(), pick_val(), m4a_pkg::IDX_W'($urandom_range(0, NELEM - 2)));
      end
    end
  endtask

  initial begin : result_sink
    int stall;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 23) == 0) result_gap_max = $urandom_range(0, 1) ? 18 : 0;
      stall = $urandom_range(0, result_gap_max);
      if (!hold_done && sb.n_results >= HOLD_AFTER) begin
        stall = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  initial begin
    int i;
    elem_ch.valid <= 1'b0;
    elem_ch.a_elem <= '0;
    elem_ch.b_elem <= '0;
    elem_ch.elem_index <= '0;
    result_ch.ready <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // first run uses the reset mode and scale
    elem_gap_max = 3;
    for (i = 0; i < NELEM; i++) send_elem(dir_a[i], dir_b[i], m4a_pkg::IDX_W'(i));
    settle(8);
    directed_op(m4a_pkg::OP_ADD, 32'h00010000, 32'h7fffffff, 32'h7fffffff);
    directed_op(m4a_pkg::OP_SUB, 32'h00010000, 32'h80000000, 32'h7fffffff);
    directed_op(m4a_pkg::OP_SCALE, 32'h7fffffff, 32'hffffffff, 32'h00000005);
    directed_op(m4a_pkg::OP_SCALE, 32'h80000000, 32'h80000000, 32'h00000000);
    directed_op(m4a_pkg::OP_SCALE, 32'h00000000, 32'h12345678, 32'h00000000);
    directed_op(m4a_pkg::OP_SCALE, 32'hffff0000, 32'h80000000, 32'h00000000);
    directed_op(m4a_pkg::OP_MUL, 32'h00010000, 32'hfffffffd, 32'h7fffffff);

    // two full loads back to back; the second waits while the receiver holds off
    elem_gap_max = 0;
    for (i = 0; i < NELEM; i++) send_elem(pick_val(), pick_val(), m4a_pkg::IDX_W'(i));
    for (i = 0; i < NELEM; i++) send_elem(pick_val(), pick_val(), m4a_pkg::IDX_W'(i));
    settle(8);

    while (sb.n_loads < ITEM_TARGET) begin
      case ($urandom_range(0, 2))
        0: elem_gap_max = 0;
        1: elem_gap_max = 4;
        default: elem_gap_max = 18;
      endcase
      if ($urandom_range(0, 3) != 0) begin
        write_reg(m4a_pkg::REG_OP_MODE, $urandom_range(0, 3));
      end
      if ($urandom_range(0, 2) == 0) write_reg(m4a_pkg::REG_SCALE, pick_scale());
      repeat ($urandom_range(1, 2)) load_burst();
      settle(8);
    end
    settle(20);

    $display("covered %0d element loads and %0d runs, %0d result elements checked",
             sb.n_loads, sb.n_runs, sb.n_results);
    $display("add, subtract, multiply and scale with extreme scale factors and a long output stall");
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/m4a_pkg.sv
rtl/m4a_if.sv
rtl/m4a_store.sv
rtl/m4a_seq.sv
rtl/m4a_alu.sv
rtl/matrix4_arith_unit.sv
bench/tb_matrix4_arith_unit.sv
